// ===== rtl/sacl_pkg.sv =====
// Shared constants and types for the set-associative LRU cache model.
package sacl_pkg;

	localparam int MAX_SET_BITS = 8;
	localparam int MAX_WAYS     = 8;
	localparam int WAY_W        = $clog2(MAX_WAYS);
	localparam int SET_W        = MAX_SET_BITS;
	localparam int LINE_W       = SET_W + WAY_W;
	localparam int SETS         = 1 << MAX_SET_BITS;
	localparam int LINES        = SETS * MAX_WAYS;
	localparam int ADDR_W       = 64;
	localparam int TAG_W        = 62;
	localparam int STAMP_W      = 64;
	localparam int CNT_W        = 32;
	localparam int SB_W         = 4;
	localparam int OB_W         = 6;
	localparam int NW_W         = WAY_W + 1;
	localparam int MAX_OB       = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

	// Line update issued by the sequencer to the line store.
	typedef struct packed {
		logic                we;
		logic                tag_we;
		logic [SET_W-1:0]    set;
		logic [WAY_W-1:0]    way;
		logic [TAG_W-1:0]    tag;
		logic [STAMP_W-1:0]  stamp;
		logic [MAX_WAYS-1:0] row;
	} store_wr_t;

	// Status of the way scan returned to the sequencer.
	typedef struct packed {
		logic             hit_now;
		logic             found;
		logic             evict;
		logic [WAY_W-1:0] way;
	} scan_res_t;

endpackage

// ===== rtl/sacl_ifs.sv =====
// Handshake channel interfaces: access requests, results and configuration writes.
interface sacl_req_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [sacl_pkg::ADDR_W-1:0] address;

	modport source (output valid, action, address, input ready);
	modport sink (input valid, action, address, output ready);
endinterface

interface sacl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic                        evicted;
	logic [sacl_pkg::WAY_W-1:0]  way_used;
	logic [sacl_pkg::SET_W-1:0]  set_index;
	logic                        last;
	logic [sacl_pkg::CNT_W-1:0]  hit_total;
	logic [sacl_pkg::CNT_W-1:0]  miss_total;
	logic [sacl_pkg::CNT_W-1:0]  eviction_total;

	modport source (output valid, hit, evicted, way_used, set_index, last, hit_total,
		miss_total, eviction_total, input ready);
	modport sink (input valid, hit, evicted, way_used, set_index, last, hit_total,
		miss_total, eviction_total, output ready);
endinterface

interface sacl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sacl_pkg::CFG_IDX_W-1:0]  index;
	logic [sacl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sacl_store.sv =====
// Line store: tag and stamp memories per line, valid rows per set with row flags.
module sacl_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              row_rd,
	input  logic [sacl_pkg::SET_W-1:0]        rd_set,
	input  logic [sacl_pkg::WAY_W-1:0]        rd_way,
	input  sacl_pkg::store_wr_t               wr,
	output logic [sacl_pkg::MAX_WAYS-1:0]     vrow,
	output logic [sacl_pkg::TAG_W-1:0]        tag_rd,
	output logic [sacl_pkg::STAMP_W-1:0]      stamp_rd
);

	logic [sacl_pkg::TAG_W-1:0]    tag_mem   [sacl_pkg::LINES];
	logic [sacl_pkg::STAMP_W-1:0]  stamp_mem [sacl_pkg::LINES];
	logic [sacl_pkg::MAX_WAYS-1:0] vmem      [sacl_pkg::SETS];
	logic [sacl_pkg::SETS-1:0]     row_ok_q;
	logic                          row_ok_rd_q;
	logic [sacl_pkg::MAX_WAYS-1:0] vmem_rd_q;
	logic [sacl_pkg::TAG_W-1:0]    tag_rd_q;
	logic [sacl_pkg::STAMP_W-1:0]  stamp_rd_q;
	logic [sacl_pkg::LINE_W-1:0]   rd_line;
	logic [sacl_pkg::LINE_W-1:0]   wr_line;

	assign rd_line = {rd_set, rd_way};
	assign wr_line = {wr.set, wr.way};

	// Tag and stamp memories: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			stamp_mem[wr_line] <= wr.stamp;
			if (wr.tag_we) begin
				tag_mem[wr_line] <= wr.tag;
			end
		end
		tag_rd_q   <= tag_mem[rd_line];
		stamp_rd_q <= stamp_mem[rd_line];
	end

	// Valid-bit rows, one per set; a row never written reads as empty.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			vmem[wr.set] <= wr.row;
		end
		if (row_rd) begin
			vmem_rd_q <= vmem[rd_set];
		end
	end

	// Row flags are cleared at reset, which empties the whole cache at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q    <= '0;
			row_ok_rd_q <= 1'b0;
		end else begin
			if (wr.we) begin
				row_ok_q[wr.set] <= 1'b1;
			end
			if (row_rd) begin
				row_ok_rd_q <= row_ok_q[rd_set];
			end
		end
	end

	assign vrow     = row_ok_rd_q ? vmem_rd_q : '0;
	assign tag_rd   = tag_rd_q;
	assign stamp_rd = stamp_rd_q;

endmodule

// ===== rtl/sacl_scan.sv =====
// Way scan unit: one tag compare and one stamp compare, applied to one way per step.
module sacl_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          step,
	input  logic [sacl_pkg::WAY_W-1:0]    way,
	input  logic                          line_valid,
	input  logic [sacl_pkg::TAG_W-1:0]    tag_rd,
	input  logic [sacl_pkg::TAG_W-1:0]    tag_ref,
	input  logic [sacl_pkg::STAMP_W-1:0]  stamp_rd,
	output sacl_pkg::scan_res_t           res
);

	logic                          found_q;
	logic                          free_q;
	logic [sacl_pkg::WAY_W-1:0]    hit_way_q;
	logic [sacl_pkg::WAY_W-1:0]    free_way_q;
	logic [sacl_pkg::WAY_W-1:0]    best_way_q;
	logic [sacl_pkg::STAMP_W-1:0]  best_q;
	logic                          hit_now;
	logic                          older;

	assign hit_now = step && line_valid && (tag_rd == tag_ref);
	assign older   = (way == '0) || (stamp_rd < best_q);

	// Hit and free-way flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (step) begin
			if (hit_now) begin
				found_q <= 1'b1;
			end else if (!line_valid) begin
				free_q <= 1'b1;
			end
		end
	end

	// Way numbers and the oldest stamp seen so far; the last invalid way wins.
	always_ff @(posedge clk) begin
		if (step) begin
			if (hit_now) begin
				hit_way_q <= way;
			end else begin
				if (!line_valid) begin
					free_way_q <= way;
				end
				if (older) begin
					best_q     <= stamp_rd;
					best_way_q <= way;
				end
			end
		end
	end

	assign res.hit_now = hit_now;
	assign res.found   = found_q;
	assign res.evict   = !found_q && !free_q;
	assign res.way     = found_q ? hit_way_q : (free_q ? free_way_q : best_way_q);

endmodule

// ===== rtl/set_assoc_cache_lru_sim_unit.sv =====
// Top level of the set-associative cache model with LRU replacement.
//
//   channel | dir | word                                        | accepted when
//   req     | in  | action, address                             | req.valid && req.ready
//   rsp     | out | hit, evicted, way_used, set_index, last,    | rsp.valid && rsp.ready
//           |     | hit_total, miss_total, eviction_total       |
//   cfg     | in  | index, data                                 | cfg.valid && cfg.ready
//
// After the accept edge an access reads the set's valid row, walks the examined ways
// (1 to ways_in_use; a hit stops the walk) and then writes its line update. A single
// tag/stamp comparator walks the ways one per cycle over line memories with one read
// and one write port. A modify runs a second access of the same kind. req is ready
// only when no access is in progress, so the next word is taken at the earliest in the
// cycle after the last line update. A result waits in the output register, and any
// access stalls before its line update until that register is free. Reset empties
// the cache at once.
module set_assoc_cache_lru_sim_unit (
	input logic        clk,
	input logic        arst_n,
	sacl_req_if.sink   req,
	sacl_rsp_if.source rsp,
	sacl_cfg_if.sink   cfg
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ROW   = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_WRITE = 2'd3;

	logic [1:0]                      state_q;
	logic [sacl_pkg::SB_W-1:0]       set_bits_q;
	logic [sacl_pkg::OB_W-1:0]       offset_bits_q;
	logic [sacl_pkg::NW_W-1:0]       ways_q;
	logic [sacl_pkg::SB_W-1:0]       sb;
	logic [sacl_pkg::OB_W-1:0]       ob;
	logic [sacl_pkg::NW_W-1:0]       nw;
	logic [sacl_pkg::OB_W:0]         shamt;
	logic [sacl_pkg::SET_W:0]        set_one;
	logic [sacl_pkg::SET_W-1:0]      set_mask;
	logic [sacl_pkg::TAG_W-1:0]      tag_q;
	logic [sacl_pkg::SET_W-1:0]      set_q;
	logic                            mod_q;
	logic                            second_q;
	logic [sacl_pkg::WAY_W-1:0]      way_q;
	logic [sacl_pkg::WAY_W-1:0]      rd_way;
	logic                            last_way;
	logic [sacl_pkg::STAMP_W-1:0]    use_clock_q;
	logic [sacl_pkg::CNT_W-1:0]      hits_q;
	logic [sacl_pkg::CNT_W-1:0]      misses_q;
	logic [sacl_pkg::CNT_W-1:0]      evs_q;
	logic [sacl_pkg::CNT_W-1:0]      hits_n;
	logic [sacl_pkg::CNT_W-1:0]      misses_n;
	logic [sacl_pkg::CNT_W-1:0]      evs_n;
	logic                            commit;
	logic [sacl_pkg::MAX_WAYS-1:0]   vrow;
	logic [sacl_pkg::TAG_W-1:0]      tag_rd;
	logic [sacl_pkg::STAMP_W-1:0]    stamp_rd;
	sacl_pkg::store_wr_t             wr;
	sacl_pkg::scan_res_t             res;

	logic                            out_valid_q;
	logic                            out_hit_q;
	logic                            out_evicted_q;
	logic [sacl_pkg::WAY_W-1:0]      out_way_q;
	logic [sacl_pkg::SET_W-1:0]      out_set_q;
	logic                            out_last_q;
	logic [sacl_pkg::CNT_W-1:0]      out_hits_q;
	logic [sacl_pkg::CNT_W-1:0]      out_misses_q;
	logic [sacl_pkg::CNT_W-1:0]      out_evs_q;

	function automatic logic [sacl_pkg::CNT_W-1:0] sat_inc(
		input logic [sacl_pkg::CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Configuration registers; writes to an unknown index are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= sacl_pkg::SB_W'(1);
			offset_bits_q <= sacl_pkg::OB_W'(1);
			ways_q        <= sacl_pkg::NW_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				sacl_pkg::REG_SET_BITS:    set_bits_q    <= cfg.data[sacl_pkg::SB_W-1:0];
				sacl_pkg::REG_OFFSET_BITS: offset_bits_q <= cfg.data[sacl_pkg::OB_W-1:0];
				sacl_pkg::REG_WAYS_IN_USE: ways_q        <= cfg.data[sacl_pkg::NW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register values are held to their legal ranges where they are used.
	always_comb begin
		if (set_bits_q == '0) begin
			sb = sacl_pkg::SB_W'(1);
		end else if (set_bits_q > sacl_pkg::SB_W'(sacl_pkg::MAX_SET_BITS)) begin
			sb = sacl_pkg::SB_W'(sacl_pkg::MAX_SET_BITS);
		end else begin
			sb = set_bits_q;
		end
		if (offset_bits_q == '0) begin
			ob = sacl_pkg::OB_W'(1);
		end else if (offset_bits_q > sacl_pkg::OB_W'(sacl_pkg::MAX_OB)) begin
			ob = sacl_pkg::OB_W'(sacl_pkg::MAX_OB);
		end else begin
			ob = offset_bits_q;
		end
		if (ways_q == '0) begin
			nw = sacl_pkg::NW_W'(1);
		end else if (ways_q > sacl_pkg::NW_W'(sacl_pkg::MAX_WAYS)) begin
			nw = sacl_pkg::NW_W'(sacl_pkg::MAX_WAYS);
		end else begin
			nw = ways_q;
		end
	end

	// Address split into tag and set.
	assign shamt    = (sacl_pkg::OB_W + 1)'(sb) + (sacl_pkg::OB_W + 1)'(ob);
	assign set_one  = (sacl_pkg::SET_W + 1)'(1);
	assign set_mask = sacl_pkg::SET_W'((set_one << sb) - set_one);

	// Way walk control.
	assign last_way = ({1'b0, way_q} == nw - 1'b1);
	assign rd_way   = (state_q == S_SCAN) ? way_q + 1'b1 : '0;
	assign commit   = (state_q == S_WRITE) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE);

	// Totals after this access.
	assign hits_n   = res.found ? sat_inc(hits_q) : hits_q;
	assign misses_n = res.found ? misses_q : sat_inc(misses_q);
	assign evs_n    = res.evict ? sat_inc(evs_q) : evs_q;

	// Line update at the end of an access.
	assign wr.we     = commit;
	assign wr.tag_we = !res.found;
	assign wr.set    = set_q;
	assign wr.way    = res.way;
	assign wr.tag    = tag_q;
	assign wr.stamp  = use_clock_q + 1'b1;
	assign wr.row    = vrow | (sacl_pkg::MAX_WAYS'(1) << res.way);

	sacl_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.row_rd   (state_q == S_ROW),
		.rd_set   (set_q),
		.rd_way   (rd_way),
		.wr       (wr),
		.vrow     (vrow),
		.tag_rd   (tag_rd),
		.stamp_rd (stamp_rd)
	);

	sacl_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == S_ROW),
		.step       (state_q == S_SCAN),
		.way        (way_q),
		.line_valid (vrow[way_q]),
		.tag_rd     (tag_rd),
		.tag_ref    (tag_q),
		.stamp_rd   (stamp_rd),
		.res        (res)
	);

	// Sequencer and running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			second_q    <= 1'b0;
			way_q       <= '0;
			use_clock_q <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evs_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						second_q <= 1'b0;
						state_q  <= S_ROW;
					end
				end
				S_ROW: begin
					way_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (res.hit_now || last_way) begin
						state_q <= S_WRITE;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				S_WRITE: begin
					if (commit) begin
						use_clock_q <= use_clock_q + 1'b1;
						hits_q      <= hits_n;
						misses_q    <= misses_n;
						evs_q       <= evs_n;
						if (mod_q && !second_q) begin
							second_q <= 1'b1;
							state_q  <= S_ROW;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request word capture.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mod_q <= req.action;
			tag_q <= sacl_pkg::TAG_W'(req.address >> shamt);
			set_q <= sacl_pkg::SET_W'(req.address >> ob) & set_mask;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_hit_q     <= res.found;
			out_evicted_q <= res.evict;
			out_way_q     <= res.way;
			out_set_q     <= set_q;
			out_last_q    <= !mod_q || second_q;
			out_hits_q    <= hits_n;
			out_misses_q  <= misses_n;
			out_evs_q     <= evs_n;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.hit            = out_hit_q;
	assign rsp.evicted        = out_evicted_q;
	assign rsp.way_used       = out_way_q;
	assign rsp.set_index      = out_set_q;
	assign rsp.last           = out_last_q;
	assign rsp.hit_total      = out_hits_q;
	assign rsp.miss_total     = out_misses_q;
	assign rsp.eviction_total = out_evs_q;

	// The way walk never goes past the ways in use.
	a_way_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> {1'b0, way_q} < nw)
		else $error("way walk went past the ways in use");

	// A hit never reports an eviction.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !(res.found && res.evict))
		else $error("hit and eviction reported together");

	// The first access of a modify is followed by the second.
	a_modify_second: assert property (@(posedge clk) disable iff (!arst_n)
		commit && mod_q && !second_q |=> state_q == S_ROW && second_q)
		else $error("modify did not start its second access");

	// A committed access always leaves a result in the output register.
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed access left no result");

	// A miss moves the miss total unless it has saturated.
	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !res.found |=> misses_q != $past(misses_q) || misses_q == '1)
		else $error("miss not counted");

endmodule

// ===== dv/sacl_lru_checker.sv =====
// Checker that predicts every cache access result and compares it with the block's output.
`timescale 1ns / 100ps
module sacl_lru_checker (
	input  logic clk,
	input  logic arst_n,
	sacl_req_if  req,
	sacl_rsp_if  rsp,
	sacl_cfg_if  cfg,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic                       hit;
		logic                       evicted;
		logic [sacl_pkg::WAY_W-1:0] way_used;
		logic [sacl_pkg::SET_W-1:0] set_index;
		logic                       last;
		logic [sacl_pkg::CNT_W-1:0] hit_total;
		logic [sacl_pkg::CNT_W-1:0] miss_total;
		logic [sacl_pkg::CNT_W-1:0] eviction_total;
	} access_word_t;

	// Shadow copy of the line store, the use clock, the totals and the geometry registers.
	logic                         line_ok    [sacl_pkg::LINES];
	logic [sacl_pkg::ADDR_W-1:0]  line_tags  [sacl_pkg::LINES];
	logic [sacl_pkg::STAMP_W-1:0] line_ages  [sacl_pkg::LINES];
	logic [sacl_pkg::STAMP_W-1:0] use_clock;
	logic [sacl_pkg::CNT_W-1:0]   hits_seen;
	logic [sacl_pkg::CNT_W-1:0]   misses_seen;
	logic [sacl_pkg::CNT_W-1:0]   evict_count;
	logic [sacl_pkg::SB_W-1:0]    set_bits;
	logic [sacl_pkg::OB_W-1:0]    offset_bits;
	logic [sacl_pkg::NW_W-1:0]    ways_in_use;
	access_word_t                 expected_words [$];

	function automatic int clamp_int(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [sacl_pkg::CNT_W-1:0] sat_inc(logic [sacl_pkg::CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// One access: look the tag up, fill or evict on a miss, stamp the line, bump the totals.
	function automatic access_word_t lru_access(logic [sacl_pkg::ADDR_W-1:0] addr,
		logic is_last);
		int sb, ob, nw, base, way, free_way;
		logic found, have_free, evict;
		logic [sacl_pkg::ADDR_W-1:0] tag, set_full;
		logic [sacl_pkg::STAMP_W-1:0] oldest;
		access_word_t word_out;
		sb = clamp_int(int'(set_bits), 1, sacl_pkg::MAX_SET_BITS);
		ob = clamp_int(int'(offset_bits), 1, sacl_pkg::MAX_OB);
		nw = clamp_int(int'(ways_in_use), 1, sacl_pkg::MAX_WAYS);
		tag = addr >> (sb + ob);
		set_full = (addr >> ob) & ((64'd1 << sb) - 64'd1);
		base = int'(set_full) * sacl_pkg::MAX_WAYS;
		found = 1'b0;
		have_free = 1'b0;
		evict = 1'b0;
		way = 0;
		free_way = 0;

		// Walk the ways in use; the last invalid way seen is the fill candidate.
		for (int w = 0; w < nw && !found; w++) begin
			if (line_ok[base + w] && line_tags[base + w] == tag) begin
				found = 1'b1;
				way = w;
			end else if (!line_ok[base + w]) begin
				have_free = 1'b1;
				free_way = w;
			end
		end

		if (found) begin
			hits_seen = sat_inc(hits_seen);
		end else begin
			misses_seen = sat_inc(misses_seen);
			if (have_free) begin
				way = free_way;
			end else begin
				// Every way is valid: replace the oldest stamp, lowest way on a tie.
				evict = 1'b1;
				evict_count = sat_inc(evict_count);
				way = 0;
				oldest = line_ages[base];
				for (int w = 1; w < nw; w++) begin
					if (line_ages[base + w] < oldest) begin
						oldest = line_ages[base + w];
						way = w;
					end
				end
			end
			line_ok[base + way] = 1'b1;
			line_tags[base + way] = tag;
		end
		use_clock = use_clock + 1'b1;
		line_ages[base + way] = use_clock;

		word_out.hit = found;
		word_out.evicted = evict;
		word_out.way_used = way[sacl_pkg::WAY_W-1:0];
		word_out.set_index = set_full[sacl_pkg::SET_W-1:0];
		word_out.last = is_last;
		word_out.hit_total = hits_seen;
		word_out.miss_total = misses_seen;
		word_out.eviction_total = evict_count;
		return word_out;
	endfunction

	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		access_word_t exp_w;
		if (!arst_n) begin
			for (int i = 0; i < sacl_pkg::LINES; i++)
				line_ok[i] = 1'b0;
			use_clock = '0;
			hits_seen = '0;
			misses_seen = '0;
			evict_count = '0;
			set_bits = sacl_pkg::SB_W'(1);
			offset_bits = sacl_pkg::OB_W'(1);
			ways_in_use = sacl_pkg::NW_W'(1);
			expected_words.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// Result words are matched against the oldest prediction.
			if (rsp.valid && rsp.ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					$display("%0t: result word expected none, got hit %0h way %0h set %0h",
						$time, rsp.hit, rsp.way_used, rsp.set_index);
				end else begin
					exp_w = expected_words.pop_front();
					compare_field("hit", 64'(exp_w.hit), 64'(rsp.hit));
					compare_field("evicted", 64'(exp_w.evicted), 64'(rsp.evicted));
					compare_field("way_used", 64'(exp_w.way_used), 64'(rsp.way_used));
					compare_field("set_index", 64'(exp_w.set_index), 64'(rsp.set_index));
					compare_field("last", 64'(exp_w.last), 64'(rsp.last));
					compare_field("hit_total", 64'(exp_w.hit_total), 64'(rsp.hit_total));
					compare_field("miss_total", 64'(exp_w.miss_total),
						64'(rsp.miss_total));
					compare_field("eviction_total", 64'(exp_w.eviction_total),
						64'(rsp.eviction_total));
				end
			end

			// Register writes keep only the bits each register holds; unknown indexes drop.
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					sacl_pkg::REG_SET_BITS: set_bits = cfg.data[sacl_pkg::SB_W-1:0];
					sacl_pkg::REG_OFFSET_BITS: offset_bits = cfg.data[sacl_pkg::OB_W-1:0];
					sacl_pkg::REG_WAYS_IN_USE: ways_in_use = cfg.data[sacl_pkg::NW_W-1:0];
					default: ;
				endcase
			end

			// A modify runs the same access twice; only the second word is the last.
			if (req.valid && req.ready) begin
				if (req.action)
					expected_words.push_back(lru_access(req.address, 1'b0));
				expected_words.push_back(lru_access(req.address, 1'b1));
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

// ===== dv/set_assoc_cache_lru_sim_unit_test.sv =====
// Test top: drives accesses and register writes into the LRU cache model and gives the verdict.
`timescale 1ns / 100ps
module set_assoc_cache_lru_sim_unit_test;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 160;
	localparam int SETTLE_CYCLES = 40;
	localparam int POOL_SIZE     = 16;
	localparam logic [sacl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	int   eff_sb, eff_ob, eff_nw;
	logic [sacl_pkg::ADDR_W-1:0] tag_pool [POOL_SIZE];

	sacl_req_if req ();
	sacl_rsp_if rsp ();
	sacl_cfg_if cfg ();

	set_assoc_cache_lru_sim_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	sacl_lru_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int clamp_int(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Idle length: mostly none, sometimes a few cycles, now and then a long stretch.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Register value: mostly in range, sometimes any byte to hit the clamping.
	function automatic logic [sacl_pkg::CFG_DATA_W-1:0] pick_raw(int lo, int hi);
		if ($urandom_range(0, 3) == 0)
			return sacl_pkg::CFG_DATA_W'($urandom_range(0, 255));
		return sacl_pkg::CFG_DATA_W'($urandom_range(lo, hi));
	endfunction

	// Addresses built from a small tag pool over a few sets, so hits and evictions
	// are common; a share of fully random addresses toggles every address bit.
	function automatic logic [sacl_pkg::ADDR_W-1:0] random_address();
		logic [sacl_pkg::ADDR_W-1:0] addr, offs;
		int sets_hot;
		if ($urandom_range(0, 99) < 15)
			return {$urandom, $urandom};
		sets_hot = (eff_sb >= 2) ? 4 : 2;
		offs = {$urandom, $urandom} & ((64'd1 << eff_ob) - 64'd1);
		addr = tag_pool[$urandom_range(0, eff_nw + 2)] << (eff_sb + eff_ob);
		addr |= 64'($urandom_range(0, sets_hot - 1)) << eff_ob;
		return addr | offs;
	endfunction

	// Result side: random back-pressure, none while calm.
	initial begin
		int stall;
		rsp.ready <= 1'b1;
		forever begin
			@(posedge clk);
			stall = calm ? 0 : gap_len();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	// Offer one access word, after an optional idle gap, and wait until it is taken.
	task automatic send_access(logic action, logic [sacl_pkg::ADDR_W-1:0] addr);
		int gap;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= action;
		req.address <= addr;
		do @(posedge clk); while (!req.ready);
	endtask

	// Stop offering accesses and wait until every predicted result has come back.
	task automatic drain_results();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Write all geometry registers plus the unused index, back to back.
	task automatic configure(logic [sacl_pkg::CFG_DATA_W-1:0] sb_raw,
		logic [sacl_pkg::CFG_DATA_W-1:0] ob_raw, logic [sacl_pkg::CFG_DATA_W-1:0] nw_raw);
		logic [sacl_pkg::CFG_IDX_W-1:0] idx [4];
		logic [sacl_pkg::CFG_DATA_W-1:0] val [4];
		idx[0] = sacl_pkg::REG_SET_BITS;
		idx[1] = sacl_pkg::REG_OFFSET_BITS;
		idx[2] = sacl_pkg::REG_WAYS_IN_USE;
		idx[3] = REG_UNUSED;
		val[0] = sb_raw;
		val[1] = ob_raw;
		val[2] = nw_raw;
		val[3] = sacl_pkg::CFG_DATA_W'($urandom_range(0, 255));
		for (int i = 0; i < 4; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data <= val[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		eff_sb = clamp_int(int'(sb_raw & 8'h0F), 1, sacl_pkg::MAX_SET_BITS);
		eff_ob = clamp_int(int'(ob_raw & 8'h3F), 1, sacl_pkg::MAX_OB);
		eff_nw = clamp_int(int'(nw_raw & 8'h0F), 1, sacl_pkg::MAX_WAYS);
	endtask

	initial begin
		req.valid <= 1'b0;
		req.action <= 1'b0;
		req.address <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= sacl_pkg::REG_SET_BITS;
		cfg.data <= '0;
		eff_sb = 1;
		eff_ob = 1;
		eff_nw = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry, one way: fill, hit, top address, modify that evicts then hits.
		send_access(1'b0, 64'h0);
		send_access(1'b0, 64'h0);
		send_access(1'b0, '1);
		send_access(1'b1, 64'h4);
		send_access(1'b0, 64'h0);
		drain_results();

		// Largest geometry: fill one set from the top way down, refresh the first line,
		// then misses evict the least recently used lines; two accesses to other sets follow.
		configure(8'd8, 8'd32, 8'd8);
		for (int k = 0; k < 8; k++)
			send_access(1'b0, (64'(k) << 40) | (64'd5 << 32));
		send_access(1'b0, 64'd5 << 32);
		send_access(1'b0, (64'd8 << 40) | (64'd5 << 32));
		send_access(1'b1, (64'd9 << 40) | (64'd5 << 32));
		send_access(1'b0, '1);
		send_access(1'b0, 64'h0000_0000_FFFF_FFFF);

		// Random phases, each under its own geometry; lines survive the changes.
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
				0: configure(8'd0, 8'd0, 8'd0);
				1: configure(8'd1, 8'd32, 8'd8);
				2: configure(8'hFF, 8'hFF, 8'hFF);
				default: configure(pick_raw(1, 8), pick_raw(1, 32), pick_raw(1, 8));
			endcase
			for (int t = 0; t < POOL_SIZE; t++)
				tag_pool[t] = {$urandom, $urandom};
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				calm <= (n >= 100 && n < 130);
				if (p == 3 && n == 60)
					drain_results();
				send_access($urandom_range(0, 3) == 0, random_address());
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
